// ----- hdl/linear_probe_hash_set_defines.svh -----
// Assertion macros used by the hash set back end (lphs_back).
`ifndef LINEAR_PROBE_HASH_SET_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_DEFINES_SVH

// Antecedent and consequent hold in the same cycle.
`define LPHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lphs assertion failed");

// Consequent holds in the cycle after the antecedent.
`define LPHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lphs assertion failed");

`endif

// ----- hdl/lphs_pkg.sv -----
package lphs_pkg;

    // The slot count must be a power of two.
    localparam int TABLE_SIZE  = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W       = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_W       = 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                  opcode;
        logic signed [KEY_W-1:0]  key;
        logic [SLOT_W-1:0]        home;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/lphs_front.sv -----
module lphs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [lphs_pkg::KEY_W-1:0]    i_s_axis_tdata,   // key
    input  logic [0:0]                    i_s_axis_tuser,   // opcode
    input  lphs_pkg::t_q_status           i_q_status,
    input  logic                          i_clearing,
    output logic                          o_push,
    output lphs_pkg::t_item               o_item
);

    logic            r_valid;
    lphs_pkg::t_item r_item;
    logic            w_accept;

    assign o_s_axis_tready = !i_clearing && (!r_valid || !i_q_status.full);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid && !i_q_status.full;
    assign o_item          = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // The home slot is the low key bits, which is the non-negative remainder.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.opcode <= lphs_pkg::t_opcode'(i_s_axis_tuser[0]);
            r_item.key    <= $signed(i_s_axis_tdata);
            r_item.home   <= i_s_axis_tdata[lphs_pkg::SLOT_W-1:0];
        end
    end

endmodule

// ----- hdl/lphs_fifo.sv -----
module lphs_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lphs_pkg::t_item     i_item,
    input  logic                i_pop,
    output lphs_pkg::t_item     o_item,
    output lphs_pkg::t_q_status o_status
);

    localparam int PTR_W = $clog2(lphs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lphs_pkg::QUEUE_DEPTH + 1);

    lphs_pkg::t_item r_mem [lphs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(lphs_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_item         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(lphs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(lphs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hdl/lphs_back.sv -----
`include "linear_probe_hash_set_defines.svh"

module lphs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lphs_pkg::t_item               i_item,
    input  lphs_pkg::t_q_status           i_q_status,
    output logic                          o_pop,
    output logic                          o_clearing,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lphs_pkg::OUT_W-1:0]    o_m_axis_tdata    // found, full_res, zero pad
);

    localparam int SW = lphs_pkg::SLOT_W;
    localparam int KW = lphs_pkg::KEY_W;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_PROBE = 3'b100
    } t_back_state;

    // Each entry holds the valid flag above the key.
    logic [KW:0]     r_mem [lphs_pkg::TABLE_SIZE];
    logic [KW:0]     r_rd_data;

    t_back_state     r_state, n_state;
    logic [SW-1:0]   r_clr_addr, n_clr_addr;
    logic [SW-1:0]   r_pos, n_pos;
    logic [SW-1:0]   r_probes, n_probes;
    lphs_pkg::t_item r_item;
    logic            r_out_valid, n_out_valid;
    logic            r_found;
    logic            r_full;

    logic            w_hit;
    logic            w_empty;
    logic            w_last;
    logic            w_done;
    logic [SW-1:0]   w_next_pos;
    logic [SW-1:0]   w_raddr;
    logic            w_we;
    logic [SW-1:0]   w_waddr;
    logic [KW:0]     w_wdata;

    assign w_empty    = !r_rd_data[KW];
    assign w_hit      = r_rd_data[KW] && (r_rd_data[KW-1:0] == $unsigned(r_item.key));
    assign w_last     = (r_probes == SW'(lphs_pkg::TABLE_SIZE - 1));
    assign w_done     = (r_state == ST_PROBE) && (w_empty || w_hit || w_last);
    assign w_next_pos = (r_pos == SW'(lphs_pkg::TABLE_SIZE - 1)) ? '0 : r_pos + SW'(1);

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_pop      = (r_state == ST_IDLE) && !i_q_status.empty &&
                        (!r_out_valid || i_m_axis_tready);

    assign w_raddr = (r_state == ST_IDLE) ? i_item.home : w_next_pos;
    assign w_we    = (r_state == ST_CLEAR) ||
                     (w_done && (r_item.opcode == lphs_pkg::OP_INSERT) && w_empty);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_pos;
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : {1'b1, $unsigned(r_item.key)};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_pos       = r_pos;
        n_probes    = r_probes;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + SW'(1);
                if (r_clr_addr == SW'(lphs_pkg::TABLE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    n_pos    = i_item.home;
                    n_probes = '0;
                    n_state  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (w_done) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_pos    = w_next_pos;
                    n_probes = r_probes + SW'(1);
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pos       <= '0;
            r_probes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pos       <= n_pos;
            r_probes    <= n_probes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (w_done) begin
            r_found <= w_hit;
            r_full  <= (r_item.opcode == lphs_pkg::OP_INSERT) && !w_hit && !w_empty;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(lphs_pkg::OUT_W - 2){1'b0}}, r_full, r_found};

    `LPHS_ASSERT_IMP(a_probe_out_free, i_clk, i_rst_n, r_state == ST_PROBE, !r_out_valid)
    `LPHS_ASSERT_IMP(a_no_pop_clear, i_clk, i_rst_n, r_state == ST_CLEAR, !o_pop)
    `LPHS_ASSERT_IMP(a_excl_flags, i_clk, i_rst_n, r_out_valid, !(r_found && r_full))
    `LPHS_ASSERT_NEXT(a_query_not_full, i_clk, i_rst_n,
        w_done && (r_item.opcode == lphs_pkg::OP_QUERY), !r_full)

endmodule

// ----- hdl/linear_probe_hash_set.sv -----
// Each transaction probes from 1 to TABLE_SIZE slots, starting at its home slot. The slot
// memory read port probes one slot per cycle; the back end takes no new transaction until
// the probe ends, while the input queue keeps accepting as long as it has room.
// Reset: synchronous, active low; afterwards a clearing pass over all TABLE_SIZE (1024) slots
// empties the slot memory, and no input transaction is accepted until it ends.
module linear_probe_hash_set (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [lphs_pkg::KEY_W-1:0]    i_s_axis_tdata,   // key
    input  logic [0:0]                    i_s_axis_tuser,   // opcode
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lphs_pkg::OUT_W-1:0]    o_m_axis_tdata    // found, full_res, zero pad
);

    lphs_pkg::t_item     w_front_item;
    lphs_pkg::t_item     w_queue_item;
    lphs_pkg::t_q_status w_q_status;
    logic                w_push;
    logic                w_pop;
    logic                w_clearing;

    lphs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_status      (w_q_status),
        .i_clearing      (w_clearing),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    lphs_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_queue_item),
        .o_status (w_q_status)
    );

    lphs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_queue_item),
        .i_q_status      (w_q_status),
        .o_pop           (w_pop),
        .o_clearing      (w_clearing),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
